// ===== src/tdrh_pkg.sv =====
`default_nettype none

package tdrh_pkg;

    localparam int DEBOUNCE_W           = 8;
    localparam int HOLD_W               = 16;
    localparam int COUNT_W              = 17;
    localparam int CFG_INDEX_W          = 2;
    localparam int CFG_DATA_W           = 16;
    localparam int ELAPSED_BITS_DEFAULT = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd4;

    // Configuration register indexes. The remaining code is unused and ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_HOLD_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_HOLD_TICKS  = 2'd2;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic                  release_hold_enable;
        logic [HOLD_W-1:0]     release_hold_ticks;
    } tdrh_cfg_t;

    typedef struct packed {
        logic trigger_pulled;
        logic click;
    } tdrh_result_t;

endpackage

`default_nettype wire

// ===== src/tdrh_core.sv =====
`default_nettype none

module tdrh_core #(
    parameter int ELAPSED_BITS = tdrh_pkg::ELAPSED_BITS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step_en,
    input  wire logic                 sample,
    input  wire tdrh_pkg::tdrh_cfg_t  cfg,
    output tdrh_pkg::tdrh_result_t    result
);

    localparam int COUNT_W = tdrh_pkg::COUNT_W;
    localparam int HOLD_W  = tdrh_pkg::HOLD_W;
    localparam int CMP_W   = (ELAPSED_BITS > HOLD_W) ? ELAPSED_BITS : HOLD_W;

    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

    logic                    last_sample_reg;
    logic                    stable_state_reg, stable_state_next;
    logic [COUNT_W-1:0]      countdown_reg, countdown_next;
    logic [ELAPSED_BITS-1:0] elapsed_reg, elapsed_next;

    logic [ELAPSED_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]        elapsed_wide;
    logic [CMP_W-1:0]        hold_wide;
    logic [CMP_W-1:0]        hold_gap;
    logic                    hold_pending;
    logic                    sample_edge;
    logic [COUNT_W-1:0]      count_load;
    logic [COUNT_W-1:0]      count_cur;
    logic                    click;

    always_comb begin
        elapsed_inc  = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                    : elapsed_reg + 1'b1;
        elapsed_wide = CMP_W'(elapsed_inc);
        hold_wide    = CMP_W'(cfg.release_hold_ticks);
        hold_gap     = hold_wide - elapsed_wide;
        // A release before the minimum hold has passed waits out the remainder.
        hold_pending = cfg.release_hold_enable && !sample && (elapsed_wide < hold_wide);
        sample_edge  = sample != last_sample_reg;
        count_load   = hold_pending
                     ? COUNT_W'(hold_gap[HOLD_W-1:0]) + COUNT_W'(cfg.debounce_ticks)
                     : COUNT_W'(cfg.debounce_ticks);
        count_cur    = sample_edge ? count_load : countdown_reg;

        if (count_cur != '0) begin
            click             = (count_cur == COUNT_W'(1));
            countdown_next    = count_cur - 1'b1;
            stable_state_next = stable_state_reg;
            elapsed_next      = elapsed_inc;
        end else begin
            click             = 1'b0;
            countdown_next    = '0;
            stable_state_next = sample;
            elapsed_next      = sample ? '0 : elapsed_inc;
        end
    end

    assign result.trigger_pulled = stable_state_next;
    assign result.click          = click;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sample_reg  <= 1'b0;
            stable_state_reg <= 1'b0;
            countdown_reg    <= '0;
            elapsed_reg      <= '0;
        end else if (step_en) begin
            last_sample_reg  <= sample;
            stable_state_reg <= stable_state_next;
            countdown_reg    <= countdown_next;
            elapsed_reg      <= elapsed_next;
        end
    end

    // A running countdown without a new edge keeps the debounced state.
    a_hold_while_counting: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && countdown_reg != '0 && sample == last_sample_reg
        |=> $stable(stable_state_reg))
        else $error("debounced state changed while countdown was running");

    a_click_ends_count: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && click |=> countdown_reg == '0)
        else $error("countdown not empty after click");

    a_pressed_clears_elapsed: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && count_cur == '0 && sample |=> elapsed_reg == '0)
        else $error("elapsed counter not restarted while pressed");

    a_idle_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(countdown_reg) && $stable(elapsed_reg))
        else $error("state moved without an item");

endmodule

`default_nettype wire

// ===== src/trigger_debounce_release_hold.sv =====
`default_nettype none

// Trigger debouncer with click strobe and optional release hold. Every item
// is one 1 ms tick carrying the raw trigger level; each accepted item yields
// exactly one result item with the debounced level and the click strobe. The
// block takes one item per cycle unless stalled: the whole tick update is one
// pass of logic between the state registers, and the result is registered in
// the output register as the item is accepted. s_ready stays high while the
// output register is empty or being taken in the same cycle. Configuration
// writes are taken in any cycle and should be made while no tick is pending.

module trigger_debounce_release_hold #(
    parameter int ELAPSED_BITS = tdrh_pkg::ELAPSED_BITS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_trigger_sample,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_trigger_pulled,
    output logic                                     m_click,

    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tdrh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tdrh_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tdrh_pkg::tdrh_cfg_t    cfg_reg;
    tdrh_pkg::tdrh_result_t core_result;
    tdrh_pkg::tdrh_result_t result_reg;
    logic                   m_valid_reg;
    logic                   step_en;

    assign s_ready   = !m_valid_reg || m_ready;
    assign step_en   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks      <= tdrh_pkg::DEBOUNCE_RESET;
            cfg_reg.release_hold_enable <= 1'b0;
            cfg_reg.release_hold_ticks  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tdrh_pkg::CFG_DEBOUNCE_TICKS: begin
                    cfg_reg.debounce_ticks <= cfg_data[tdrh_pkg::DEBOUNCE_W-1:0];
                end
                tdrh_pkg::CFG_RELEASE_HOLD_ENABLE: begin
                    cfg_reg.release_hold_enable <= cfg_data[0];
                end
                tdrh_pkg::CFG_RELEASE_HOLD_TICKS: begin
                    cfg_reg.release_hold_ticks <= cfg_data[tdrh_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    tdrh_core #(
        .ELAPSED_BITS(ELAPSED_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .sample  (s_trigger_sample),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            result_reg <= core_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_trigger_pulled = result_reg.trigger_pulled;
    assign m_click          = result_reg.click;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int ELAPSED_W   = tdrh_pkg::ELAPSED_BITS_DEFAULT;
    localparam int QUIET_LIMIT = 4000;

    // Index 3 names no register: writes to it must be ignored.
    localparam logic [tdrh_pkg::CFG_INDEX_W-1:0] REG_NONE = 2'd3;

    typedef enum bit [1:0] {TICK_CHECKED, TICK_TYPED, REG_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                           kind;
        logic [tdrh_pkg::CFG_INDEX_W-1:0]    index;
        logic [tdrh_pkg::CFG_DATA_W-1:0]     data;
        bit                                  sample;
        bit                                  pulled;
        bit                                  click;
    } stim_row_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic                                s_trigger_sample = 1'b0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic                                m_trigger_pulled;
    logic                                m_click;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [tdrh_pkg::CFG_INDEX_W-1:0]    cfg_index = tdrh_pkg::CFG_DEBOUNCE_TICKS;
    logic [tdrh_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // Register copies and debouncer state as the block should hold them.
    logic [tdrh_pkg::DEBOUNCE_W-1:0]     set_debounce = tdrh_pkg::DEBOUNCE_RESET;
    logic                                set_hold_enable = 1'b0;
    logic [tdrh_pkg::HOLD_W-1:0]         set_hold_ticks = '0;
    logic                                pred_last_sample = 1'b0;
    logic [tdrh_pkg::COUNT_W-1:0]        pred_countdown = '0;
    logic                                pred_pulled = 1'b0;
    logic [ELAPSED_W-1:0]                pred_elapsed = '0;

    tdrh_pkg::tdrh_result_t              pending_results[$];
    int                                  error_count = 0;
    int                                  results_seen = 0;
    int                                  stall_left = 0;
    int                                  ready_mode = 0;
    int                                  mode_left = 0;
    int                                  burst_left = 0;
    int                                  quiet_cycles = 0;

    // Directed ticks start from the reset settings: debounce 4, no release hold.
    stim_row_t directed_rows [34] = '{
        '{TICK_TYPED,   REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b1, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b1, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b1, 1'b0, 1'b0},
        '{TICK_TYPED,   REG_NONE,                          16'h0000, 1'b1, 1'b0, 1'b1},
        '{TICK_TYPED,   REG_NONE,                          16'h0000, 1'b1, 1'b1, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        // Upper data bits are dropped, so this sets a zero debounce.
        '{REG_WRITE,    tdrh_pkg::CFG_DEBOUNCE_TICKS,      16'hFF00, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_TYPED,   REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_TYPED,   REG_NONE,                          16'h0000, 1'b1, 1'b1, 1'b0},
        '{TICK_TYPED,   REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{REG_WRITE,    REG_NONE,                          16'hFFFF, 1'b0, 1'b0, 1'b0},
        '{TICK_TYPED,   REG_NONE,                          16'h0000, 1'b1, 1'b1, 1'b0},
        '{REG_WRITE,    tdrh_pkg::CFG_DEBOUNCE_TICKS,      16'h00FF, 1'b0, 1'b0, 1'b0},
        '{REG_WRITE,    tdrh_pkg::CFG_RELEASE_HOLD_ENABLE, 16'hFFFF, 1'b0, 1'b0, 1'b0},
        '{REG_WRITE,    tdrh_pkg::CFG_RELEASE_HOLD_TICKS,  16'hFFFF, 1'b0, 1'b0, 1'b0},
        // Early release against the longest hold loads the largest countdown.
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b1, 1'b0, 1'b0},
        '{REG_WRITE,    tdrh_pkg::CFG_DEBOUNCE_TICKS,      16'h0002, 1'b0, 1'b0, 1'b0},
        '{REG_WRITE,    tdrh_pkg::CFG_RELEASE_HOLD_TICKS,  16'h0003, 1'b0, 1'b0, 1'b0},
        // Release with the hold already met, then a press and a short hold.
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b1, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b1, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b1, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0},
        '{TICK_CHECKED, REG_NONE,                          16'h0000, 1'b0, 1'b0, 1'b0}
    };

    trigger_debounce_release_hold #(
        .ELAPSED_BITS(ELAPSED_W)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_trigger_sample (s_trigger_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_trigger_pulled (m_trigger_pulled),
        .m_click          (m_click),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // One 1 ms tick of the debouncer: advances the expected state and returns
    // the result item that the tick must produce.
    task automatic debounce_tick(input bit sample, output tdrh_pkg::tdrh_result_t result);
        result.click = 1'b0;
        if (pred_elapsed != '1) begin
            pred_elapsed = pred_elapsed + 1'b1;
        end
        if (sample != pred_last_sample) begin
            if (set_hold_enable && !sample && pred_elapsed < set_hold_ticks) begin
                pred_countdown = tdrh_pkg::COUNT_W'(set_hold_ticks - pred_elapsed)
                               + tdrh_pkg::COUNT_W'(set_debounce);
            end else begin
                pred_countdown = tdrh_pkg::COUNT_W'(set_debounce);
            end
        end
        pred_last_sample = sample;
        if (pred_countdown != '0) begin
            if (pred_countdown == tdrh_pkg::COUNT_W'(1)) begin
                result.click = 1'b1;
            end
            pred_countdown = pred_countdown - 1'b1;
        end else begin
            pred_pulled = pred_last_sample;
            if (pred_pulled) begin
                pred_elapsed = '0;
            end
        end
        result.trigger_pulled = pred_pulled;
    endtask

    // Offers one tick item; the sender runs in bursts with random gaps between.
    task automatic offer_tick(input bit sample, input bit typed,
                              input tdrh_pkg::tdrh_result_t typed_result);
        tdrh_pkg::tdrh_result_t predicted;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_trigger_sample <= sample;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        debounce_tick(sample, predicted);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // Registers are only written once every expected result has come back.
    task automatic write_reg(input logic [tdrh_pkg::CFG_INDEX_W-1:0] index,
                             input logic [tdrh_pkg::CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            tdrh_pkg::CFG_DEBOUNCE_TICKS:      set_debounce = data[tdrh_pkg::DEBOUNCE_W-1:0];
            tdrh_pkg::CFG_RELEASE_HOLD_ENABLE: set_hold_enable = data[0];
            tdrh_pkg::CFG_RELEASE_HOLD_TICKS:  set_hold_ticks = data[tdrh_pkg::HOLD_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly clean presses and releases held for lengths around the debounce
    // and hold times, with some bursts of bounce in between.
    task automatic run_random_phase(input int debounce, input int enable, input int hold,
                                    input int budget);
        int left;
        int run;
        bit level;
        write_reg(tdrh_pkg::CFG_DEBOUNCE_TICKS, tdrh_pkg::CFG_DATA_W'(debounce));
        write_reg(tdrh_pkg::CFG_RELEASE_HOLD_ENABLE, tdrh_pkg::CFG_DATA_W'(enable));
        write_reg(tdrh_pkg::CFG_RELEASE_HOLD_TICKS, tdrh_pkg::CFG_DATA_W'(hold));
        level = pred_last_sample;
        left = budget;
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                run = $urandom_range(1, 6);
                if (run > left) run = left;
                repeat (run) offer_tick(1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
                level = !level;
                case ($urandom_range(0, 3))
                    0: run = $urandom_range(1, 3);
                    1: run = debounce + $urandom_range(0, 3);
                    2: run = debounce + hold + $urandom_range(0, 6);
                    default: run = $urandom_range(1, 2 * (debounce + hold) + 8);
                endcase
                if (run < 1) run = 1;
                if (run > left) run = left;
                repeat (run) offer_tick(level, 1'b0, '0);
            end
            left -= run;
        end
    endtask

    always @(posedge aclk) begin : result_check
        tdrh_pkg::tdrh_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result item with none expected (pulled %0b click %0b)",
                         $time, m_trigger_pulled, m_click);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_trigger_pulled !== want.trigger_pulled) begin
                    $display("%0t: trigger_pulled expected %0b, got %0b",
                             $time, want.trigger_pulled, m_trigger_pulled);
                    error_count++;
                end
                if (m_click !== want.click) begin
                    $display("%0t: click expected %0b, got %0b",
                             $time, want.click, m_click);
                    error_count++;
                end
            end
            results_seen++;
            // Two long hold-offs while the sender keeps offering fill the block.
            if (results_seen == 150 || results_seen == 400) begin
                stall_left = 400;
            end
        end
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[trigger_debounce_release_hold] ERROR");
            $finish;
        end
    end

    initial begin
        tdrh_pkg::tdrh_result_t typed_result;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == REG_WRITE) begin
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end else begin
                typed_result.trigger_pulled = directed_rows[i].pulled;
                typed_result.click = directed_rows[i].click;
                offer_tick(directed_rows[i].sample, directed_rows[i].kind == TICK_TYPED,
                           typed_result);
            end
        end

        run_random_phase(4, 0, 0, 80);
        run_random_phase(0, 1, 0, 60);
        run_random_phase(1, 1, 5, 70);
        run_random_phase(3, 1, 20, 80);
        run_random_phase(2, 0, 7, 50);
        run_random_phase(255, 1, 10, 100);
        run_random_phase($urandom_range(0, 15), 1, $urandom_range(0, 40), 70);

        // Get the output pressed at once, then release against the longest hold
        // and debounce: the countdown is loaded close to its full 17-bit length.
        write_reg(tdrh_pkg::CFG_DEBOUNCE_TICKS, '0);
        write_reg(tdrh_pkg::CFG_RELEASE_HOLD_ENABLE, '0);
        offer_tick(1'b0, 1'b0, '0);
        offer_tick(1'b1, 1'b0, '0);
        write_reg(tdrh_pkg::CFG_DEBOUNCE_TICKS, 16'h00FF);
        write_reg(tdrh_pkg::CFG_RELEASE_HOLD_ENABLE, 16'h0001);
        write_reg(tdrh_pkg::CFG_RELEASE_HOLD_TICKS, 16'hFFFF);
        repeat (20) offer_tick(1'b0, 1'b0, '0);
        offer_tick(1'b1, 1'b0, '0);
        repeat (10) offer_tick(1'b0, 1'b0, '0);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (error_count == 0) begin
            $display("[trigger_debounce_release_hold] OK");
        end else begin
            $display("[trigger_debounce_release_hold] ERROR");
        end
        $finish;
    end

endmodule
